// ===== rtl/fdx_pkg.sv =====
package fdx_pkg;

  localparam int SAMPLE_W = 32;
  localparam int VALUE_W  = 64;

  typedef logic [VALUE_W-1:0] value_t;

  // One word of the wave that travels down the row of difference cells.
  typedef struct packed {
    logic   active;
    logic   last;
    logic   ovf;
    logic   neg;
    value_t diff;
    value_t acc_next;
    value_t acc_prev;
  } wave_t;

endpackage

// ===== rtl/fdx_cell.sv =====
module fdx_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          advance,
  input  logic          up_vld,
  input  fdx_pkg::wave_t up_wave,
  output logic          dn_vld,
  output fdx_pkg::wave_t dn_wave
);
  import fdx_pkg::*;

  logic   filled_r, filled_nxt;
  value_t newest_r, newest_nxt;
  value_t leading_r, leading_nxt;
  logic   dn_vld_r;
  wave_t  dn_wave_r, dn_wave_nxt;

  always_comb begin
    filled_nxt  = filled_r;
    newest_nxt  = newest_r;
    leading_nxt = leading_r;
    dn_wave_nxt = up_wave;
    dn_wave_nxt.neg    = ~up_wave.neg;
    dn_wave_nxt.active = up_wave.active & filled_r;
    if (up_vld && up_wave.active) begin
      if (filled_r) begin
        newest_nxt       = up_wave.diff;
        dn_wave_nxt.diff = up_wave.diff - newest_r;
      end else begin
        newest_nxt  = up_wave.diff;
        leading_nxt = up_wave.diff;
        filled_nxt  = 1'b1;
      end
    end
    if (up_vld && up_wave.last) begin
      if (filled_nxt) begin
        dn_wave_nxt.acc_next = up_wave.acc_next + newest_nxt;
        if (up_wave.neg) begin
          dn_wave_nxt.acc_prev = up_wave.acc_prev - leading_nxt;
        end else begin
          dn_wave_nxt.acc_prev = up_wave.acc_prev + leading_nxt;
        end
      end
      filled_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r <= 1'b0;
      dn_vld_r <= 1'b0;
    end else if (advance) begin
      filled_r <= filled_nxt;
      dn_vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      newest_r  <= newest_nxt;
      leading_r <= leading_nxt;
      dn_wave_r <= dn_wave_nxt;
    end
  end

  assign dn_vld  = dn_vld_r;
  assign dn_wave = dn_wave_r;

endmodule

// ===== rtl/finite_difference_extrapolator.sv =====
// Extrapolates a sampled polynomial sequence forward and backward by finite
// differences. Samples enter one word per cycle unless the row stalls; a
// sequence ends with the word that has in_last_sample set. That word yields
// one result holding the next value, the previous value and a flag that is
// set when more than MAX_LEN samples arrived (extra samples are ignored). The
// datapath is a row of MAX_LEN difference cells, each doing a 64-bit subtract,
// a 64-bit add and a 64-bit add or subtract per cycle; out_valid rises once the
// last sample has passed every cell register and the output register. A new
// sequence may start in the cycle right after the last sample. The whole row
// stalls only while a result waits at the output. All arithmetic wraps
// modulo 2^64.
module finite_difference_extrapolator #(
  parameter int MAX_LEN = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [fdx_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                                 in_last_sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [fdx_pkg::VALUE_W-1:0]   out_next_value,
  output logic signed [fdx_pkg::VALUE_W-1:0]   out_prev_value,
  output logic                                 out_too_long
);
  import fdx_pkg::*;

  localparam int CntW = $clog2(MAX_LEN + 1);

  logic            advance;
  logic            accept;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            ovf_r, ovf_nxt;
  logic            room;
  logic            wave_vld [0:MAX_LEN];
  wave_t           wave     [0:MAX_LEN];
  logic            out_valid_r;
  value_t          out_next_r;
  value_t          out_prev_r;
  logic            out_too_long_r;

  assign advance = !out_valid_r || out_ready;
  assign in_ready = advance;
  assign accept = in_valid && advance;
  assign room = (cnt_r != CntW'(MAX_LEN));

  always_comb begin
    wave_vld[0]      = in_valid;
    wave[0].active   = room;
    wave[0].last     = in_last_sample;
    wave[0].ovf      = ovf_r | ~room;
    wave[0].neg      = 1'b0;
    wave[0].diff     = {{(VALUE_W - SAMPLE_W){in_sample[SAMPLE_W-1]}}, in_sample};
    wave[0].acc_next = '0;
    wave[0].acc_prev = '0;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (accept) begin
      if (in_last_sample) begin
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
      end else if (room) begin
        cnt_nxt = cnt_r + CntW'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
    fdx_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .advance (advance),
      .up_vld  (wave_vld[k]),
      .up_wave (wave[k]),
      .dn_vld  (wave_vld[k+1]),
      .dn_wave (wave[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && wave_vld[MAX_LEN] && wave[MAX_LEN].last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && wave_vld[MAX_LEN] && wave[MAX_LEN].last) begin
      out_next_r     <= wave[MAX_LEN].acc_next;
      out_prev_r     <= wave[MAX_LEN].acc_prev;
      out_too_long_r <= wave[MAX_LEN].ovf;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_next_value = out_next_r;
  assign out_prev_value = out_prev_r;
  assign out_too_long   = out_too_long_r;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(MAX_LEN))
    else $error("sample count beyond depth");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (cnt_r == CntW'(MAX_LEN)))
    else $error("overflow flagged before the row was full");

  a_seq_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last_sample) |=> (cnt_r == '0 && !ovf_r))
    else $error("sequence state not cleared after last word");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(wave_vld[MAX_LEN]))
    else $error("cell row moved during an output stall");
`endif

endmodule

// ===== test/finite_difference_extrapolator_checker.sv =====
module finite_difference_extrapolator_checker #(
  parameter int MAX_LEN = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [fdx_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                          in_last_sample,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [fdx_pkg::VALUE_W-1:0]   out_next_value,
  input  logic [fdx_pkg::VALUE_W-1:0]   out_prev_value,
  input  logic                          out_too_long,
  output int                            mismatches,
  output int                            outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import fdx_pkg::*;

  typedef struct packed {
    value_t next_value;
    value_t prev_value;
    logic   too_long;
  } extrapolation_t;

  value_t         newest_row [MAX_LEN];
  value_t         leading_row[MAX_LEN];
  int unsigned    held_samples;
  bit             overflowed;
  extrapolation_t expected_extrapolations[$];
  int             fault_count = 0;

  task automatic clear_rows();
    foreach (newest_row[k]) begin
      newest_row[k]  = '0;
      leading_row[k] = '0;
    end
    held_samples = 0;
    overflowed   = 1'b0;
  endtask

  task automatic absorb_sample(input logic [SAMPLE_W-1:0] s, input logic fin);
    value_t         v;
    value_t         old;
    extrapolation_t e;
    if (held_samples < MAX_LEN) begin
      v = {{(VALUE_W-SAMPLE_W){s[SAMPLE_W-1]}}, s};
      for (int k = 0; k < held_samples; k++) begin
        old = newest_row[k];
        newest_row[k] = v;
        v = v - old;
      end
      newest_row[held_samples]  = v;
      leading_row[held_samples] = v;
      held_samples++;
    end else begin
      overflowed = 1'b1;
    end
    if (fin) begin
      e.next_value = '0;
      e.prev_value = '0;
      for (int k = 0; k < held_samples; k++) begin
        e.next_value = e.next_value + newest_row[k];
        if (k % 2 == 1) begin
          e.prev_value = e.prev_value - leading_row[k];
        end else begin
          e.prev_value = e.prev_value + leading_row[k];
        end
      end
      e.too_long = overflowed;
      expected_extrapolations.insert(expected_extrapolations.size(), e);
      clear_rows();
    end
  endtask

  initial clear_rows();

  always @(posedge clk) begin
    extrapolation_t want;
    if (!rst_n) begin
      clear_rows();
      expected_extrapolations.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_extrapolations.size() == 0) begin
          $display("%0t: unexpected result word: next %0d prev %0d too_long %0b", $time,
                   $signed(out_next_value), $signed(out_prev_value), out_too_long);
          fault_count++;
        end else begin
          want = expected_extrapolations.pop_front();
          if (out_next_value !== want.next_value) begin
            $display("%0t: next_value expected %0d, got %0d", $time,
                     $signed(want.next_value), $signed(out_next_value));
            fault_count++;
          end
          if (out_prev_value !== want.prev_value) begin
            $display("%0t: prev_value expected %0d, got %0d", $time,
                     $signed(want.prev_value), $signed(out_prev_value));
            fault_count++;
          end
          if (out_too_long !== want.too_long) begin
            $display("%0t: too_long expected %0b, got %0b", $time,
                     want.too_long, out_too_long);
            fault_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        absorb_sample(in_sample, in_last_sample);
      end
    end
    mismatches  <= fault_count;
    outstanding <= expected_extrapolations.size();
  end

endmodule

// ===== test/finite_difference_extrapolator_tb.sv =====
module finite_difference_extrapolator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEN      = 32;
  localparam int RANDOM_WORDS = 550;
  localparam int DRAIN_CYCLES = MAX_LEN + 16;

  typedef enum int {
    POLY_CONTENT,
    NOISE_CONTENT,
    EXTREME_CONTENT
  } content_e;

  logic                                clk = 1'b0;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_ready;
  logic signed [fdx_pkg::SAMPLE_W-1:0] in_sample;
  logic                                in_last_sample;
  logic                                out_valid;
  logic                                out_ready;
  logic signed [fdx_pkg::VALUE_W-1:0]  out_next_value;
  logic signed [fdx_pkg::VALUE_W-1:0]  out_prev_value;
  logic                                out_too_long;
  int                                  mismatches;
  int                                  outstanding;
  bit                                  calm;
  int                                  words_sent;

  always #4 clk = ~clk;

  finite_difference_extrapolator #(
    .MAX_LEN(MAX_LEN)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample     (in_sample),
    .in_last_sample(in_last_sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_next_value(out_next_value),
    .out_prev_value(out_prev_value),
    .out_too_long  (out_too_long)
  );

  finite_difference_extrapolator_checker #(
    .MAX_LEN(MAX_LEN)
  ) i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample     (in_sample),
    .in_last_sample(in_last_sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_next_value(out_next_value),
    .out_prev_value(out_prev_value),
    .out_too_long  (out_too_long),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  task automatic send_word(input logic [fdx_pkg::SAMPLE_W-1:0] s, input logic fin);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_sample      <= s;
    in_last_sample <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic send_sequence(input int len, input content_e content);
    int                          coef[5];
    int                          deg;
    int                          base;
    longint                      acc;
    longint                      x;
    logic [fdx_pkg::SAMPLE_W-1:0] s;
    deg  = $urandom_range(0, 4);
    base = $urandom_range(0, 200) - 100;
    foreach (coef[i]) coef[i] = $urandom_range(0, 40) - 20;
    for (int n = 0; n < len; n++) begin
      case (content)
        POLY_CONTENT: begin
          acc = 0;
          x   = base + n;
          for (int d = deg; d >= 0; d--) acc = acc * x + coef[d];
          s = acc[fdx_pkg::SAMPLE_W-1:0];
        end
        NOISE_CONTENT: begin
          s = $urandom();
        end
        default: begin
          case ($urandom_range(0, 4))
            0: s = 32'h7fff_ffff;
            1: s = 32'h8000_0000;
            2: s = '0;
            3: s = '1;
            default: s = $urandom();
          endcase
        end
      endcase
      send_word(s, n == len - 1);
    end
  endtask

  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      int gap;
      gap = calm ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    #2_000_000;
    $display("finite_difference_extrapolator regression: fail");
    $finish;
  end

  initial begin
    int       len;
    int       r;
    content_e content;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_sample      <= '0;
    in_last_sample <= 1'b0;
    calm       = 1'b0;
    words_sent = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single-word sequences at the extremes, then wrapping pairs, a cubic run and a short mixed-sign run.
    send_word(32'h7fff_ffff, 1'b1);
    send_word(32'h8000_0000, 1'b1);
    send_word(32'h0000_0000, 1'b1);
    send_word(32'hffff_ffff, 1'b1);
    send_word(32'h7fff_ffff, 1'b0);
    send_word(32'h8000_0000, 1'b1);
    send_word(32'h8000_0000, 1'b0);
    send_word(32'h7fff_ffff, 1'b1);
    for (int n = 1; n <= 6; n++) send_word(n * n * n, n == 6);
    send_word(-5, 1'b0);
    send_word(3, 1'b0);
    send_word(-9, 1'b1);
    wait_for_results();

    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      r = $urandom_range(0, 9);
      if (r < 6) begin
        len = $urandom_range(1, 6);
      end else if (r < 8) begin
        len = $urandom_range(7, MAX_LEN - 1);
      end else if (r == 8) begin
        len = MAX_LEN;
      end else begin
        len = $urandom_range(MAX_LEN + 1, MAX_LEN + 8);
      end
      r = $urandom_range(0, 4);
      if (r < 3) begin
        content = POLY_CONTENT;
      end else if (r == 3) begin
        content = NOISE_CONTENT;
      end else begin
        content = EXTREME_CONTENT;
      end
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 19) == 0) begin
        wait_for_results();
      end
      send_sequence(len, content);
    end
    calm = 1'b0;

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("finite_difference_extrapolator regression: pass");
    end else begin
      $display("finite_difference_extrapolator regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/fdx_pkg.sv
rtl/fdx_cell.sv
rtl/finite_difference_extrapolator.sv
test/finite_difference_extrapolator_checker.sv
test/finite_difference_extrapolator_tb.sv
